@@ hdl/linear_rate_ramp_generator_unit_assert.svh @@
// assertion macros for the ramp generator controller
// no dependencies; lrrg_ctrl takes it in by include
`ifndef LINEAR_RATE_RAMP_GENERATOR_UNIT_ASSERT_SVH
`define LINEAR_RATE_RAMP_GENERATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define LRRG_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
// condition must never be seen outside reset
`define LRRG_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define LRRG_ASSERT(label, clk, rst_n, prop)
`define LRRG_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hdl/lrrg_pkg.sv @@
// shared widths, state codes and command/status structs of the ramp generator
// no dependencies
package lrrg_pkg;

	localparam int RATE_W    = 16;
	localparam int TIME_W    = 32;
	localparam int PROD_W    = RATE_W + TIME_W;
	localparam int DIV_STEPS = RATE_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_START_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 2'd2;

	localparam logic OP_ADVANCE = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} lrrg_state_t;

	typedef struct packed {
		logic load;      // item transfer: update elapsed time
		logic mul;       // form magnitude product
		logic prep;      // form dividend, seed remainder
		logic div_step;  // one restoring divide step
		logic out_load;  // load result register
	} lrrg_cmd_t;

	typedef struct packed {
		logic at_target; // rate is plain target, divide not needed
	} lrrg_sts_t;

endpackage

@@ hdl/lrrg_dp.sv @@
// datapath: config registers, elapsed time, multiplier, serial divider, result register
// depends on lrrg_pkg
module lrrg_dp import lrrg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	input  logic                 op,
	input  logic [TIME_W-1:0]    step_us,
	input  lrrg_cmd_t            cmd,
	output lrrg_sts_t            sts,
	output logic [RATE_W-1:0]    rate,
	output logic                 ramp_done,
	output logic [TIME_W-1:0]    elapsed_us
);

	logic [RATE_W-1:0] start_q;
	logic [RATE_W-1:0] target_q;
	logic [TIME_W-1:0] dur_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [PROD_W-1:0] prod_q;
	logic              dec_q;
	logic              at_target_q;
	logic [TIME_W-1:0] rem_q;
	logic [RATE_W-1:0] quo_q;   // dividend low bits, shifted out as quotient bits come in
	logic [RATE_W-1:0] rate_q;
	logic              done_q;
	logic [TIME_W-1:0] elapsed_out_q;

	logic [TIME_W:0]     sum;
	logic [TIME_W-1:0]   elapsed_next;
	logic [RATE_W-1:0]   mag;
	logic [PROD_W-1:0]   dividend;
	logic [TIME_W+1:0]   trial;
	logic [RATE_W-1:0]   rate_next;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			target_q <= '0;
			dur_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_RATE:  start_q  <= cfg_data[RATE_W-1:0];
				REG_TARGET_RATE: target_q <= cfg_data[RATE_W-1:0];
				REG_DURATION:    dur_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// elapsed time, saturating at the duration, cleared on restart
	always_comb begin
		sum = {1'b0, elapsed_q} + {1'b0, step_us};
		elapsed_next = elapsed_q;
		if (op == OP_RESTART) begin
			elapsed_next = '0;
		end else if (elapsed_q < dur_q) begin
			elapsed_next = (sum > {1'b0, dur_q}) ? dur_q : sum[TIME_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
		end else if (cmd.load) begin
			elapsed_q <= elapsed_next;
		end
	end

	// product stage
	assign mag = (target_q < start_q) ? (start_q - target_q) : (target_q - start_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q      <= mag * elapsed_q;
			dec_q       <= target_q < start_q;
			at_target_q <= elapsed_q >= dur_q;
		end
	end

	assign sts.at_target = at_target_q;

	// falling ramp rounds the quotient up
	assign dividend = dec_q ? (prod_q + {{RATE_W{1'b0}}, dur_q} - PROD_W'(1)) : prod_q;

	// restoring divider; quotient stays below 2^16 so the upper 32 bits seed the remainder
	assign trial = {1'b0, rem_q, quo_q[RATE_W-1]} - {2'b00, dur_q};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rem_q <= dividend[PROD_W-1:RATE_W];
			quo_q <= dividend[RATE_W-1:0];
		end else if (cmd.div_step) begin
			if (!trial[TIME_W+1]) begin
				rem_q <= trial[TIME_W-1:0];
			end else begin
				rem_q <= {rem_q[TIME_W-2:0], quo_q[RATE_W-1]};
			end
			quo_q <= {quo_q[RATE_W-2:0], ~trial[TIME_W+1]};
		end
	end

	always_comb begin
		if (at_target_q) begin
			rate_next = target_q;
		end else if (dec_q) begin
			rate_next = start_q - quo_q;
		end else begin
			rate_next = start_q + quo_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rate_q        <= rate_next;
			done_q        <= at_target_q;
			elapsed_out_q <= elapsed_q;
		end
	end

	assign rate       = rate_q;
	assign ramp_done  = done_q;
	assign elapsed_us = elapsed_out_q;

endmodule

@@ hdl/lrrg_ctrl.sv @@
// controller: sequences update, multiply, divide and result hand-off
// depends on lrrg_pkg and linear_rate_ramp_generator_unit_assert.svh
`include "linear_rate_ramp_generator_unit_assert.svh"
module lrrg_ctrl import lrrg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  lrrg_sts_t sts,
	output lrrg_cmd_t cmd
);

	lrrg_state_t      state_q;
	lrrg_state_t      state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = sts.at_target ? ST_FIN : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.prep) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`LRRG_ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.out_load && out_valid_q && !out_ready)
	`LRRG_ASSERT(a_div_starts_clear, clk, arst_n, (state_q == ST_PREP) |=> (cnt_q == '0))
	`LRRG_ASSERT(a_result_from_fin, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_FIN))

endmodule

@@ hdl/linear_rate_ramp_generator_unit.sv @@
// linear ramp rate generator: each item passes multiply, dividend prep, the 16-step
// serial divider and the result register; the divider is bypassed when the ramp is done
// or the duration is zero; one item in flight, the next is taken once a result is loaded
// the result register lets the next item start while a result waits for its transfer
// arst_n clears control, config registers and elapsed time; rates and duration reset to 0
// depends on lrrg_pkg, lrrg_ctrl, lrrg_dp
module linear_rate_ramp_generator_unit import lrrg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes, taken at once
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	// input items
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [TIME_W-1:0]    step_us,
	// result items
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RATE_W-1:0]    rate,
	output logic                 ramp_done,
	output logic [TIME_W-1:0]    elapsed_us
);

	// command and status between controller and datapath
	lrrg_cmd_t cmd;
	lrrg_sts_t sts;

	// controller: one item in flight, result register decoupled from the output side
	lrrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: elapsed update on transfer, product, dividend, serial divide, result
	lrrg_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.op         (op),
		.step_us    (step_us),
		.cmd        (cmd),
		.sts        (sts),
		.rate       (rate),
		.ramp_done  (ramp_done),
		.elapsed_us (elapsed_us)
	);

endmodule

@@ verif/tb_linear_rate_ramp_generator_unit.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the linear ramp rate generator: directed corners, random ramps
// under several idling mixes and an output hold-off, all checked against an in-bench predictor
// depends on lrrg_pkg and linear_rate_ramp_generator_unit
module tb_linear_rate_ramp_generator_unit;
	import lrrg_pkg::*;

	// spare register slot, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned DRAIN_CYCLES = 30;   // comfortably above the time from input transfer to result valid
	localparam int unsigned HOLD_CYCLES  = 400;  // long output hold-off
	localparam int unsigned PRINT_CAP    = 30;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              done;
		logic [TIME_W-1:0] elapsed;
	} ramp_out_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TIME_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 op;
	logic [TIME_W-1:0]    step_us;
	logic                 out_valid;
	logic                 out_ready;
	logic [RATE_W-1:0]    rate;
	logic                 ramp_done;
	logic [TIME_W-1:0]    elapsed_us;

	// predictor copy of the block's registers and elapsed time
	logic [RATE_W-1:0] cfg_start_rate;
	logic [RATE_W-1:0] cfg_target_rate;
	logic [TIME_W-1:0] cfg_duration;
	logic [TIME_W-1:0] ramp_elapsed;

	ramp_out_t awaited_outputs[$];

	// idling knobs, percent of cycles
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;

	// output hold-off, counted in its own process
	logic        hold_kick = 1'b0;
	int unsigned hold_left = 0;

	int unsigned cycle_count    = 0;
	int unsigned mismatches     = 0;
	int unsigned items_sent     = 0;
	int unsigned restarts_sent  = 0;
	int unsigned results_seen   = 0;
	int unsigned results_at_end = 0;
	int unsigned ramps_set      = 0;

	linear_rate_ramp_generator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.step_us    (step_us),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rate       (rate),
		.ramp_done  (ramp_done),
		.elapsed_us (elapsed_us)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit, any hang ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// hold-off counter: a kick loads it, it then counts down to zero
	always @(posedge clk) begin
		if (hold_kick)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// receiver: random stalls, forced low during a hold-off
	always @(posedge clk)
		out_ready <= (hold_left == 0) && !hold_kick && ($urandom_range(99) >= stall_pct);

	// predictor: elapsed time update, then the floored linear interpolation
	function automatic ramp_out_t ramp_next_output(input logic op_i, input logic [TIME_W-1:0] step_i);
		logic [TIME_W:0] sum;
		logic [63:0]     s64, t64, d64, e64, mag, q;
		ramp_out_t       res;
		if (op_i == OP_RESTART) begin
			ramp_elapsed = '0;
		end else if (ramp_elapsed < cfg_duration) begin
			// 33 bit sum so a long step cannot wrap
			sum = {1'b0, ramp_elapsed} + {1'b0, step_i};
			if (sum > {1'b0, cfg_duration})
				sum = {1'b0, cfg_duration};
			ramp_elapsed = sum[TIME_W-1:0];
		end
		s64 = cfg_start_rate;
		t64 = cfg_target_rate;
		d64 = cfg_duration;
		e64 = ramp_elapsed;
		if (d64 == 0 || e64 >= d64) begin
			res.rate = cfg_target_rate;
		end else if (t64 >= s64) begin
			mag = t64 - s64;
			q = (mag * e64) / d64;
			res.rate = cfg_start_rate + q[RATE_W-1:0];
		end else begin
			// falling ramp: flooring the rate means the drop is rounded up
			mag = s64 - t64;
			q = (mag * e64 + d64 - 1) / d64;
			res.rate = cfg_start_rate - q[RATE_W-1:0];
		end
		res.done    = (ramp_elapsed >= cfg_duration);
		res.elapsed = ramp_elapsed;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
			input logic [TIME_W-1:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
	endtask

	// result check, sampled mid-cycle so the transfer at the next edge is already decided
	always @(negedge clk) begin : check_results
		ramp_out_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (awaited_outputs.size() == 0) begin
				report_mismatch("result with nothing awaited, rate", TIME_W'(rate), '0);
			end else begin
				want = awaited_outputs.pop_front();
				if (rate !== want.rate)
					report_mismatch("rate", TIME_W'(rate), TIME_W'(want.rate));
				if (ramp_done !== want.done)
					report_mismatch("ramp_done", TIME_W'(ramp_done), TIME_W'(want.done));
				if (elapsed_us !== want.elapsed)
					report_mismatch("elapsed_us", elapsed_us, want.elapsed);
				if (want.done)
					results_at_end++;
			end
			results_seen++;
		end
	end

	// one input transfer; entered just after a rising edge, returns just after the transfer edge
	// with valid still high so that a following item can go out back to back
	task automatic send_item(input logic op_i, input logic [TIME_W-1:0] step_i);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= op_i;
		step_us  <= step_i;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		awaited_outputs.push_back(ramp_next_output(op_i, step_i));
		items_sent++;
		if (op_i == OP_RESTART)
			restarts_sent++;
		@(posedge clk);
	endtask

	// drop valid, wait for every awaited result, then let the pipeline empty out
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// full register set in consecutive cycles, plus a write to the spare slot
	task automatic program_ramp(input logic [TIME_W-1:0] start_w, input logic [TIME_W-1:0] target_w,
			input logic [TIME_W-1:0] dur_w);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_RATE;
		cfg_data  <= start_w;
		@(posedge clk);
		cfg_index <= REG_TARGET_RATE;
		cfg_data  <= target_w;
		@(posedge clk);
		cfg_index <= REG_DURATION;
		cfg_data  <= dur_w;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data  <= $urandom();
		@(posedge clk);
		cfg_we <= 1'b0;
		// upper bits of the rate writes are dropped by the block
		cfg_start_rate  = start_w[RATE_W-1:0];
		cfg_target_rate = target_w[RATE_W-1:0];
		cfg_duration    = dur_w;
		ramps_set++;
	endtask

	function automatic logic [TIME_W-1:0] pick_rate();
		logic [TIME_W-1:0] v;
		v = $urandom();
		case ($urandom_range(3))
			0:       v[RATE_W-1:0] = '0;
			1:       v[RATE_W-1:0] = '1;
			default: v[RATE_W-1:0] = RATE_W'($urandom_range(65535));
		endcase
		return v;
	endfunction

	function automatic logic [TIME_W-1:0] pick_duration();
		case ($urandom_range(5))
			0:       return '0;
			1:       return 32'd1;
			2:       return $urandom_range(64, 2);
			3:       return $urandom_range(100000);
			4:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// registers straight out of reset: zero duration, so target rate and done on every item
	task automatic test_reset_defaults();
		send_item(OP_ADVANCE, '0);
		send_item(OP_ADVANCE, '1);
		send_item(OP_RESTART, 32'h5a5a_5a5a);
	endtask

	// rising ramp: partial steps, a zero step, overshoot, advance once done, restart
	task automatic test_rising_ramp();
		program_ramp(32'd100, 32'd65535, 32'd1000);
		send_item(OP_RESTART, '0);
		send_item(OP_ADVANCE, 32'd1);
		send_item(OP_ADVANCE, 32'd250);
		send_item(OP_ADVANCE, '0);
		send_item(OP_ADVANCE, 32'd1000);
		send_item(OP_ADVANCE, 32'd7);
		send_item(OP_RESTART, '1);
	endtask

	// falling ramp over a tiny duration, stepped to the end and once past it
	task automatic test_falling_ramp();
		program_ramp(32'd65535, 32'd0, 32'd3);
		send_item(OP_RESTART, '0);
		send_item(OP_ADVANCE, 32'd1);
		send_item(OP_ADVANCE, 32'd1);
		send_item(OP_ADVANCE, 32'd1);
		send_item(OP_ADVANCE, 32'd1);
	endtask

	// full span rates, longest duration, a step sum beyond 32 bits, masked rate writes
	task automatic test_wide_span();
		program_ramp(32'habcd_0000, 32'h1234_ffff, '1);
		send_item(OP_RESTART, '0);
		send_item(OP_ADVANCE, 32'hffff_fffe);
		send_item(OP_ADVANCE, '1);
	endtask

	// duration cut below the elapsed time: elapsed holds, ramp counts as done
	task automatic test_duration_lowered();
		program_ramp(32'd5, 32'd6000, 32'd100000);
		send_item(OP_RESTART, '0);
		send_item(OP_ADVANCE, 32'd70000);
		program_ramp(32'd5, 32'd6000, 32'd1000);
		send_item(OP_ADVANCE, 32'd5);
		send_item(OP_RESTART, '0);
		send_item(OP_ADVANCE, 32'd400);
	endtask

	// random ramps: each burst restarts, then mostly steps scaled to the duration,
	// with some raw 32 bit steps and stray restarts mixed in
	task automatic test_random_ramps(input int unsigned n_items, input int unsigned idle_pct,
			input int unsigned stall_in);
		int unsigned       sent;
		int unsigned       sel;
		logic [TIME_W-1:0] burst_len;
		logic [TIME_W-1:0] step_cap;
		logic [TIME_W-1:0] dur_w;
		send_idle_pct = idle_pct;
		stall_pct     = stall_in;
		sent = 0;
		while (sent < n_items) begin
			dur_w = pick_duration();
			program_ramp(pick_rate(), pick_rate(), dur_w);
			burst_len = $urandom_range(30, 8);
			step_cap  = (dur_w / burst_len) * 2 + 1;
			for (int unsigned i = 0; i < burst_len; i++) begin
				sel = $urandom_range(99);
				if (i == 0 || sel < 6)
					send_item(OP_RESTART, $urandom());
				else if (sel < 16)
					send_item(OP_ADVANCE, $urandom());
				else
					send_item(OP_ADVANCE, $urandom_range(step_cap));
				sent++;
			end
		end
	endtask

	// long output hold-off while items keep coming, so the block stalls its input,
	// then a full pause until everything is back before a last few items
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		program_ramp(32'd40000, 32'd20, 32'd5000);
		hold_kick <= 1'b1;
		@(posedge clk);
		hold_kick <= 1'b0;
		send_item(OP_RESTART, '0);
		for (int unsigned i = 0; i < 11; i++)
			send_item(OP_ADVANCE, $urandom_range(600));
		settle();
		for (int unsigned i = 0; i < 5; i++)
			send_item(OP_ADVANCE, $urandom_range(2000));
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_START_RATE;
		cfg_data  = '0;
		in_valid  = 1'b0;
		op        = OP_ADVANCE;
		step_us   = '0;
		out_ready = 1'b0;
		cfg_start_rate  = '0;
		cfg_target_rate = '0;
		cfg_duration    = '0;
		ramp_elapsed    = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_rising_ramp();
		test_falling_ramp();
		test_wide_span();
		test_duration_lowered();
		test_random_ramps(85, 0, 0);
		test_random_ramps(85, 87, 0);
		test_random_ramps(85, 0, 87);
		test_random_ramps(85, 13, 13);
		test_output_backpressure();
		settle();

		while (awaited_outputs.size() != 0) begin
			report_mismatch("result never arrived, rate", '0, TIME_W'(awaited_outputs[0].rate));
			void'(awaited_outputs.pop_front());
		end
		$display("ramp run: %0d items sent (%0d restarts) over %0d register settings",
			items_sent, restarts_sent, ramps_set);
		$display("ramp run: %0d results checked, %0d at ramp end, %0d mismatches",
			results_seen, results_at_end, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/lrrg_pkg.sv
hdl/lrrg_dp.sv
hdl/lrrg_ctrl.sv
hdl/linear_rate_ramp_generator_unit.sv
verif/tb_linear_rate_ramp_generator_unit.sv
